// ===== hw/rtl/fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcd_pkg
// shared types and constants of the fan curve duty controller
// ----------------------------------------------------------------------------
`default_nettype none
package fcd_pkg;
    localparam int TEMP_W = 16;
    localparam int PCT_W  = 7;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam logic [1:0] MIX_MIN = 2'd0;
    localparam logic [1:0] MIX_MAX = 2'd1;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_GATED   = 2'd1;
    localparam logic [1:0] ST_SAME    = 2'd2;
    localparam logic [1:0] ST_CHANGED = 2'd3;

    localparam logic [2:0] REG_CURVE01 = 3'd0;
    localparam logic [2:0] REG_CURVE23 = 3'd1;
    localparam logic [2:0] REG_CURVE45 = 3'd2;
    localparam logic [2:0] REG_CURVE67 = 3'd3;
    localparam logic [2:0] REG_COUNT   = 3'd4;
    localparam logic [2:0] REG_MIX     = 3'd5;
    localparam logic [2:0] REG_GATE    = 3'd6;
    localparam logic [2:0] REG_STEP    = 3'd7;

    // request to the shared restoring divider
    typedef struct packed {
        logic        start;
        logic [31:0] num;   // non-negative dividend
        logic [31:0] den;   // positive divisor
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fcd_div.sv =====
// ----------------------------------------------------------------------------
// fcd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module fcd_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire fcd_pkg::div_req_t req,
    output fcd_pkg::div_rsp_t     rsp
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start) den_reg <= req.den;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/fan_curve_duty_controller.sv =====
// ----------------------------------------------------------------------------
// fan_curve_duty_controller
// one fan channel: sensor merge, change gate, curve lookup, slew-limited duty
// ----------------------------------------------------------------------------
// One input transaction is taken while s_axis_tready is high; the block then
// works on it alone and presents one result transaction. Sensors are merged
// one per cycle, the curve is searched one point per cycle, and the averaging
// and interpolation divisions share one restoring divider. An item gated
// after a minimum or maximum merge needs no division, an average needs one,
// and an interpolation one more. The result is held until m_axis_tready is
// high; the block then returns to idle and only there takes the next input.
`default_nettype none
module fan_curve_duty_controller #(
    parameter int MAX_POINTS  = 8,
    parameter int NUM_SENSORS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // fields from bit 0: temp_0 .. temp_(NUM_SENSORS-1), 16 bits each
    input  wire logic [NUM_SENSORS*16-1:0] s_axis_tdata,
    // temp_valid, bit i for sensor i
    input  wire logic [NUM_SENSORS-1:0]    s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // fields from bit 0: duty_percent[6:0], duty_changed[7], status[9:8],
    // mixed_temp[25:10], zero fill to 32 bits
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int SCNT_W = $clog2(NUM_SENSORS + 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MERGE = 3'd1;
    localparam logic [2:0] S_AVG   = 3'd2;
    localparam logic [2:0] S_GATE  = 3'd3;
    localparam logic [2:0] S_SRCH  = 3'd4;
    localparam logic [2:0] S_INTP  = 3'd5;
    localparam logic [2:0] S_STEP  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // configuration
    logic [63:0] curve_reg [4];
    logic [3:0]  pcount_reg;
    logic [1:0]  mix_reg;
    logic [15:0] gate_reg;
    logic [6:0]  mstep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) curve_reg[k] <= '0;
            pcount_reg <= '0;
            mix_reg    <= 2'd2;
            gate_reg   <= 16'd128;
            mstep_reg  <= 7'd5;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fcd_pkg::REG_CURVE01: curve_reg[0] <= cfg_wdata;
                fcd_pkg::REG_CURVE23: curve_reg[1] <= cfg_wdata;
                fcd_pkg::REG_CURVE45: curve_reg[2] <= cfg_wdata;
                fcd_pkg::REG_CURVE67: curve_reg[3] <= cfg_wdata;
                fcd_pkg::REG_COUNT:   pcount_reg <= cfg_wdata[3:0];
                fcd_pkg::REG_MIX:     mix_reg    <= cfg_wdata[1:0];
                fcd_pkg::REG_GATE:    gate_reg   <= cfg_wdata[15:0];
                fcd_pkg::REG_STEP:    mstep_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // curve point access by index
    function automatic logic signed [15:0] pt_temp(input logic [2:0] i);
        logic [63:0] r;
        r = curve_reg[i[2:1]];
        return i[0] ? r[47:32] : r[15:0];
    endfunction
    function automatic logic [6:0] pt_pct(input logic [2:0] i);
        logic [63:0] r;
        r = curve_reg[i[2:1]];
        return i[0] ? r[54:48] : r[22:16];
    endfunction
    function automatic logic [6:0] clamp7(input logic [6:0] v);
        return (v > fcd_pkg::PCT_MAX) ? fcd_pkg::PCT_MAX : v;
    endfunction

    // effective point count, capped at MAX_POINTS
    logic [3:0] npts;
    assign npts = (pcount_reg > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : pcount_reg;

    // state
    logic [2:0]  st_reg, st_next;
    logic [NUM_SENSORS*16-1:0] smp_reg;
    logic [NUM_SENSORS-1:0]    vld_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [SCNT_W-1:0] scnt_reg;
    logic signed [15:0] mn_reg, mx_reg, mixed_reg;
    logic signed [19:0] sum_reg;
    logic [2:0]  pidx_reg;
    logic signed [15:0] last_temp_reg;
    logic        have_temp_reg;
    logic [6:0]  last_duty_reg;
    logic        have_duty_reg;
    logic        neg_reg;
    logic [6:0]  target_reg;
    logic [31:0] out_reg;

    fcd_pkg::div_req_t dreq;
    fcd_pkg::div_rsp_t drsp;
    logic div_wait_reg;

    fcd_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign s_axis_tready = (st_reg == S_IDLE);
    assign m_axis_tvalid = (st_reg == S_OUT);
    assign m_axis_tdata  = out_reg;

    // current sample under merge
    logic signed [15:0] cur_smp;
    assign cur_smp = smp_reg[sidx_reg*16 +: 16];

    // gate distance
    logic signed [16:0] gdiff;
    logic [16:0] gabs;
    assign gdiff = 17'(mixed_reg) - 17'(last_temp_reg);
    assign gabs  = gdiff[16] ? 17'(-gdiff) : 17'(gdiff);

    // interpolation operands, segment pidx-1 .. pidx
    logic signed [16:0] iden, ioff;
    logic signed [7:0]  idp;
    logic signed [31:0] inum;
    logic [2:0] pprev;
    assign pprev = pidx_reg - 3'd1;
    assign iden  = 17'(pt_temp(pidx_reg)) - 17'(pt_temp(pprev));
    assign ioff  = 17'(mixed_reg) - 17'(pt_temp(pprev));
    assign idp   = 8'(pt_pct(pidx_reg)) - 8'(pt_pct(pprev));
    assign inum  = 32'($signed({1'b0, pt_pct(pprev)})) * 32'(iden)
                 + 32'(ioff) * 32'(idp);

    // slew step
    logic [6:0]  cur_d, res_d;
    logic signed [8:0] sdiff;
    logic [7:0]  sabs;
    logic signed [8:0] sres;
    assign cur_d = have_duty_reg ? last_duty_reg : 7'd0;
    assign sdiff = 9'(target_reg) - 9'(cur_d);
    assign sabs  = sdiff[8] ? 8'(-sdiff) : 8'(sdiff);

    always_comb begin
        logic [7:0] lim;
        lim = (sabs < 8'(mstep_reg)) ? sabs : 8'(mstep_reg);
        sres = sdiff[8] ? 9'(cur_d) - 9'(lim) : 9'(cur_d) + 9'(lim);
        if (sres < 0) res_d = 7'd0;
        else if (sres > 9'sd100) res_d = fcd_pkg::PCT_MAX;
        else res_d = sres[6:0];
    end

    // division result with sign applied, kept at full 32-bit width
    logic signed [31:0] dsigned;
    assign dsigned = neg_reg ? -$signed(drsp.quo) : $signed(drsp.quo);

    always_comb begin
        st_next   = st_reg;
        dreq      = '0;
        case (st_reg)
            S_AVG: if (!div_wait_reg) begin
                dreq.start = 1'b1;
                dreq.num = sum_reg[19] ? 32'(-(sum_reg <<< 1)) + 32'(scnt_reg)
                                       : 32'(sum_reg <<< 1) + 32'(scnt_reg);
                dreq.den = 32'(scnt_reg) << 1;
            end
            S_INTP: if (!div_wait_reg) begin
                dreq.start = 1'b1;
                dreq.num = inum[31] ? 32'(-(inum <<< 1)) + 32'(iden)
                                    : 32'(inum <<< 1) + 32'(iden);
                dreq.den = 32'(iden) << 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            have_temp_reg <= 1'b0;
            have_duty_reg <= 1'b0;
            last_temp_reg <= '0;
            last_duty_reg <= '0;
            div_wait_reg  <= 1'b0;
        end else begin
            unique case (st_reg)
                S_IDLE: if (s_axis_tvalid) begin
                    smp_reg  <= s_axis_tdata;
                    vld_reg  <= s_axis_tuser;
                    sidx_reg <= '0;
                    scnt_reg <= '0;
                    sum_reg  <= '0;
                    mn_reg   <= '0;
                    mx_reg   <= '0;
                    st_reg   <= S_MERGE;
                end
                S_MERGE: begin
                    if (vld_reg[sidx_reg]) begin
                        if (scnt_reg == '0 || cur_smp < mn_reg) mn_reg <= cur_smp;
                        if (scnt_reg == '0 || cur_smp > mx_reg) mx_reg <= cur_smp;
                        sum_reg  <= sum_reg + 20'(cur_smp);
                        scnt_reg <= scnt_reg + SCNT_W'(1);
                    end
                    if (32'(sidx_reg) == NUM_SENSORS - 1) begin
                        if (vld_reg == '0) begin
                            out_reg <= {6'd0, 16'd0, fcd_pkg::ST_NONE, 1'b0,
                                        last_duty_reg};
                            st_reg  <= S_OUT;
                        end else if (mix_reg == fcd_pkg::MIX_MIN) begin
                            mixed_reg <= (vld_reg[sidx_reg] &&
                                (scnt_reg == '0 || cur_smp < mn_reg)) ? cur_smp : mn_reg;
                            st_reg <= S_GATE;
                        end else if (mix_reg == fcd_pkg::MIX_MAX) begin
                            mixed_reg <= (vld_reg[sidx_reg] &&
                                (scnt_reg == '0 || cur_smp > mx_reg)) ? cur_smp : mx_reg;
                            st_reg <= S_GATE;
                        end else begin
                            st_reg <= S_AVG;
                        end
                    end else begin
                        sidx_reg <= sidx_reg + SIDX_W'(1);
                    end
                end
                S_AVG: begin
                    if (!div_wait_reg) begin
                        div_wait_reg <= 1'b1;
                        neg_reg      <= sum_reg[19];
                    end else if (drsp.done) begin
                        div_wait_reg <= 1'b0;
                        mixed_reg    <= dsigned[15:0];
                        st_reg       <= S_GATE;
                    end
                end
                S_GATE: begin
                    if (have_temp_reg && gabs < 17'(gate_reg)) begin
                        last_temp_reg <= mixed_reg;
                        out_reg <= {6'd0, mixed_reg, fcd_pkg::ST_GATED, 1'b0,
                                    last_duty_reg};
                        st_reg  <= S_OUT;
                    end else if (npts == 4'd0) begin
                        target_reg <= 7'd0;
                        st_reg     <= S_STEP;
                    end else if (mixed_reg <= pt_temp(3'd0)) begin
                        target_reg <= clamp7(pt_pct(3'd0));
                        st_reg     <= S_STEP;
                    end else if (mixed_reg >= pt_temp(3'(npts - 4'd1))) begin
                        target_reg <= clamp7(pt_pct(3'(npts - 4'd1)));
                        st_reg     <= S_STEP;
                    end else begin
                        pidx_reg <= 3'd1;
                        st_reg   <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (mixed_reg <= pt_temp(pidx_reg)) st_reg <= S_INTP;
                    else pidx_reg <= pidx_reg + 3'd1;
                end
                S_INTP: begin
                    if (!div_wait_reg) begin
                        div_wait_reg <= 1'b1;
                        neg_reg      <= inum[31];
                    end else if (drsp.done) begin
                        div_wait_reg <= 1'b0;
                        if (dsigned < 0) target_reg <= 7'd0;
                        else if (dsigned > 32'sd100) target_reg <= fcd_pkg::PCT_MAX;
                        else target_reg <= dsigned[6:0];
                        st_reg <= S_STEP;
                    end
                end
                S_STEP: begin
                    logic [6:0] nd;
                    logic       chg;
                    nd  = (target_reg != cur_d) ? res_d : cur_d;
                    chg = !have_duty_reg || nd != last_duty_reg;
                    if (chg) begin
                        last_duty_reg <= nd;
                        have_duty_reg <= 1'b1;
                    end
                    last_temp_reg <= mixed_reg;
                    have_temp_reg <= 1'b1;
                    out_reg <= {6'd0, mixed_reg,
                                chg ? fcd_pkg::ST_CHANGED : fcd_pkg::ST_SAME, chg,
                                chg ? nd : last_duty_reg};
                    st_reg <= S_OUT;
                end
                S_OUT: if (m_axis_tready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a reported change always carries the changed status code
    a_chg_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[7] == (m_axis_tdata[9:8] == fcd_pkg::ST_CHANGED)))
        else $error("changed flag and status disagree");
    // duty never leaves 0..100
    a_duty_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= fcd_pkg::PCT_MAX))
        else $error("duty out of range");
    // no new transaction is taken while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
`endif
endmodule
`default_nettype wire
